/* design/c3wr_pkg.sv */
`default_nettype none
package c3wr_pkg;

    localparam int unsigned CMD_WEIGHT = 0;
    localparam int unsigned CMD_VOXEL  = 1;

    localparam int unsigned CFG_DEPTH  = 0;
    localparam int unsigned CFG_HEIGHT = 1;
    localparam int unsigned CFG_WIDTH  = 2;
    localparam int unsigned CFG_STRIDE = 3;

    typedef struct packed {
        logic               command;
        logic [9:0]         weight_index;
        logic signed [15:0] value;
    } c3wr_in_t;

    typedef struct packed {
        logic [2:0]  out_channel;
        logic [5:0]  out_plane;
        logic [5:0]  out_row;
        logic [5:0]  out_col;
        logic [14:0] activation;
        logic        last_of_run;
    } c3wr_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store_sample;
        logic store_weight;
        logic clear_acc;
        logic mac_en;
        logic latch_result;
    } c3wr_cmd_t;

endpackage
`default_nettype wire

/* design/conv3d_window_relu_unit.sv */
`default_nettype none
// Streaming 3D convolution with ReLU. Beats with command 0 load one kernel weight; beats with
// command 1 carry one voxel sample of one input channel, in plane, row, column, channel order.
// When a channel beat completes a stride-aligned window, the block emits CHANNELS_OUT results,
// one per output channel, the last marked by last_of_run. Each result is a dot product of
// CHANNELS_IN*KERNEL_SIZE^3 terms computed by a single multiply-accumulate unit, one term a
// cycle; no new beat is accepted while a window is computed or a result awaits m_ready.
// Samples are Q8.8, weights Q2.13, results Q7.8 saturated to 0..32767. Configuration must be
// written only while the block is idle; the block itself does not enforce this.
module conv3d_window_relu_unit #(
    parameter int CHANNELS_IN  = 4,
    parameter int CHANNELS_OUT = 8,
    parameter int KERNEL_SIZE  = 3,
    parameter int MAX_COLS     = 64,
    parameter int MAX_ROWS     = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire c3wr_pkg::c3wr_in_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output c3wr_pkg::c3wr_out_t       m_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [6:0]           cfg_data
);
    import c3wr_pkg::*;

    c3wr_cmd_t   cmd;
    logic [2:0]  wr_slot, rd_slot;
    logic [7:0]  wr_row, wr_col, rd_row, rd_col;
    logic [3:0]  wr_chan, rd_chan;
    logic [15:0] rd_widx;
    logic [5:0]  res_ochan, res_plane, res_row, res_col;
    logic        res_last;

    assign cfg_ready = 1'b1;

    c3wr_ctrl #(
        .CHANNELS_IN(CHANNELS_IN), .CHANNELS_OUT(CHANNELS_OUT), .KERNEL_SIZE(KERNEL_SIZE),
        .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)
    ) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_valid), .in_ready(s_ready),
        .item(s_data), .out_ready(m_ready), .out_valid(m_valid),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cmd(cmd), .wr_slot(wr_slot), .wr_row(wr_row), .wr_col(wr_col),
        .wr_chan(wr_chan), .rd_slot(rd_slot), .rd_row(rd_row), .rd_col(rd_col),
        .rd_chan(rd_chan), .rd_widx(rd_widx), .res_ochan(res_ochan),
        .res_plane(res_plane), .res_row(res_row), .res_col(res_col), .res_last(res_last)
    );

    c3wr_datapath #(
        .CHANNELS_IN(CHANNELS_IN), .CHANNELS_OUT(CHANNELS_OUT), .KERNEL_SIZE(KERNEL_SIZE),
        .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)
    ) u_dp (
        .aclk(aclk), .cmd(cmd), .item(s_data), .wr_slot(wr_slot), .wr_row(wr_row),
        .wr_col(wr_col), .wr_chan(wr_chan), .rd_slot(rd_slot), .rd_row(rd_row),
        .rd_col(rd_col), .rd_chan(rd_chan), .rd_widx(rd_widx), .res_ochan(res_ochan),
        .res_plane(res_plane), .res_row(res_row), .res_col(res_col),
        .res_last(res_last), .result(m_data)
    );
endmodule
`default_nettype wire

/* design/c3wr_datapath.sv */
`default_nettype none
module c3wr_datapath #(
    parameter int CHANNELS_IN  = 4,
    parameter int CHANNELS_OUT = 8,
    parameter int KERNEL_SIZE  = 3,
    parameter int MAX_COLS     = 64,
    parameter int MAX_ROWS     = 64
) (
    input  wire logic                  aclk,
    input  wire c3wr_pkg::c3wr_cmd_t   cmd,
    input  wire c3wr_pkg::c3wr_in_t    item,
    input  wire logic [2:0]            wr_slot,
    input  wire logic [7:0]            wr_row,
    input  wire logic [7:0]            wr_col,
    input  wire logic [3:0]            wr_chan,
    input  wire logic [2:0]            rd_slot,
    input  wire logic [7:0]            rd_row,
    input  wire logic [7:0]            rd_col,
    input  wire logic [3:0]            rd_chan,
    input  wire logic [15:0]           rd_widx,
    input  wire logic [5:0]            res_ochan,
    input  wire logic [5:0]            res_plane,
    input  wire logic [5:0]            res_row,
    input  wire logic [5:0]            res_col,
    input  wire logic                  res_last,
    output c3wr_pkg::c3wr_out_t        result
);
    import c3wr_pkg::*;

    localparam int KCUBE   = KERNEL_SIZE * KERNEL_SIZE * KERNEL_SIZE;
    localparam int WCOUNT  = CHANNELS_OUT * CHANNELS_IN * KCUBE;
    localparam int CI_W    = (CHANNELS_IN > 1) ? $clog2(CHANNELS_IN) : 1;
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int SLOT_W  = (KERNEL_SIZE > 1) ? $clog2(KERNEL_SIZE) : 1;
    localparam int PADDR_W = SLOT_W + ROW_W + COL_W + CI_W;
    localparam int PCOUNT  = 1 << PADDR_W;
    localparam int WADDR_W = $clog2(WCOUNT);

    logic signed [15:0] weight_mem [WCOUNT];
    logic signed [15:0] plane_mem  [PCOUNT];
    logic signed [15:0] samp_reg, wgt_reg;
    logic signed [31:0] prod_reg;
    logic signed [47:0] acc_reg;
    logic               samp_vld_reg;
    logic               prod_vld_reg;
    logic [PADDR_W-1:0] waddr, raddr;
    logic [14:0]        act;
    logic [34:0]        rounded;

    assign waddr = {wr_slot[SLOT_W-1:0], wr_row[ROW_W-1:0], wr_col[COL_W-1:0],
                    wr_chan[CI_W-1:0]};
    assign raddr = {rd_slot[SLOT_W-1:0], rd_row[ROW_W-1:0], rd_col[COL_W-1:0],
                    rd_chan[CI_W-1:0]};

    always_ff @(posedge aclk) begin
        if (cmd.store_weight) begin
            weight_mem[item.weight_index[WADDR_W-1:0]] <= item.value;
        end
        wgt_reg <= weight_mem[rd_widx[WADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.store_sample) begin
            plane_mem[waddr] <= item.value;
        end
        samp_reg <= plane_mem[raddr];
    end

    // The memory read and the product each add one register stage, and the valid bit
    // follows both before a term reaches the accumulator.
    always_ff @(posedge aclk) begin
        samp_vld_reg <= cmd.mac_en;
        prod_vld_reg <= samp_vld_reg;
        prod_reg     <= samp_reg * wgt_reg;
        if (cmd.clear_acc) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + 48'(prod_reg);
        end
    end

    always_comb begin
        rounded = 35'(acc_reg[47:13]) + 35'(acc_reg[12]);
        if (acc_reg <= 0) begin
            act = '0;
        end else if (rounded > 35'd32767) begin
            act = 15'h7FFF;
        end else begin
            act = rounded[14:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_result) begin
            result.out_channel <= res_ochan[2:0];
            result.out_plane   <= res_plane;
            result.out_row     <= res_row;
            result.out_col     <= res_col;
            result.activation  <= act;
            result.last_of_run <= res_last;
        end
    end
endmodule
`default_nettype wire

/* design/c3wr_ctrl.sv */
`default_nettype none
module c3wr_ctrl #(
    parameter int CHANNELS_IN  = 4,
    parameter int CHANNELS_OUT = 8,
    parameter int KERNEL_SIZE  = 3,
    parameter int MAX_COLS     = 64,
    parameter int MAX_ROWS     = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire c3wr_pkg::c3wr_in_t  item,
    input  wire logic                out_ready,
    output logic                     out_valid,
    input  wire logic                cfg_valid,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [6:0]          cfg_data,
    output c3wr_pkg::c3wr_cmd_t      cmd,
    output logic [2:0]               wr_slot,
    output logic [7:0]               wr_row,
    output logic [7:0]               wr_col,
    output logic [3:0]               wr_chan,
    output logic [2:0]               rd_slot,
    output logic [7:0]               rd_row,
    output logic [7:0]               rd_col,
    output logic [3:0]               rd_chan,
    output logic [15:0]              rd_widx,
    output logic [5:0]               res_ochan,
    output logic [5:0]               res_plane,
    output logic [5:0]               res_row,
    output logic [5:0]               res_col,
    output logic                     res_last
);
    import c3wr_pkg::*;

    localparam int KCUBE  = KERNEL_SIZE * KERNEL_SIZE * KERNEL_SIZE;
    localparam int WCOUNT = CHANNELS_OUT * CHANNELS_IN * KCUBE;
    localparam int KM     = KERNEL_SIZE - 1;

    typedef enum logic [2:0] {S_IDLE, S_MAC, S_DRAIN, S_RES, S_OUT} state_t;

    state_t      state_reg;
    logic [6:0]  depth_reg, height_reg, width_reg;
    logic [2:0]  stride_reg;
    logic [3:0]  chan_reg;
    logic [7:0]  col_reg, row_reg;
    logic [6:0]  plane_reg;
    logic [2:0]  slot_reg;
    // Window walk counters: input channel, kd, kh, kw and output channel.
    logic [3:0]  wi_reg;
    logic [2:0]  kd_reg, kh_reg, kw_reg;
    logic [5:0]  oc_reg;
    logic [15:0] widx_reg;
    logic [2:0]  drain_reg;
    logic [7:0]  wrow_reg, wcol_reg;
    logic [2:0]  wslot_reg;
    logic [5:0]  opl_reg, orow_reg, ocol_reg;
    logic        out_valid_reg;

    logic [6:0]  depth_e;
    logic [7:0]  height_e, width_e;
    logic [2:0]  st_e;
    logic [3:0]  chan_c;
    logic [7:0]  col_c, row_c;
    logic [6:0]  dp, dr, dc;
    logic        fire, accept, last_tap;
    logic [3:0]  kslot_sum;
    logic [2:0]  kslot;

    // Quotient by a stride of 1 to 4; a third is taken as x*43/128, exact below 128.
    function automatic logic [6:0] div_stride(input logic [6:0] x, input logic [2:0] s);
        logic [13:0] prod;
        prod = {7'd0, x} * 14'd43;
        case (s)
            3'd2:    div_stride = {1'b0, x[6:1]};
            3'd3:    div_stride = prod[13:7];
            3'd4:    div_stride = {2'b00, x[6:2]};
            default: div_stride = x;
        endcase
    endfunction

    function automatic logic stride_aligned(input logic [6:0] x, input logic [2:0] s);
        logic [6:0] q;
        q = div_stride(x, s);
        case (s)
            3'd2:    stride_aligned = !x[0];
            3'd3:    stride_aligned = (x == 7'({q, 1'b0} + {1'b0, q}));
            3'd4:    stride_aligned = (x[1:0] == 2'b00);
            default: stride_aligned = 1'b1;
        endcase
    endfunction

    always_comb begin
        depth_e  = (depth_reg == 0) ? 7'd1 : (depth_reg > 7'd64 ? 7'd64 : depth_reg);
        height_e = (height_reg == 0) ? 8'd1 :
                   (32'(height_reg) > MAX_ROWS ? 8'(MAX_ROWS) : 8'(height_reg));
        width_e  = (width_reg == 0) ? 8'd1 :
                   (32'(width_reg) > MAX_COLS ? 8'(MAX_COLS) : 8'(width_reg));
        st_e     = (stride_reg == 0) ? 3'd1 : (stride_reg > 3'd4 ? 3'd4 : stride_reg);
        chan_c   = (32'(chan_reg) >= CHANNELS_IN) ? 4'd0 : chan_reg;
        col_c    = (32'(col_reg) >= MAX_COLS) ? 8'd0 : col_reg;
        row_c    = (32'(row_reg) >= MAX_ROWS) ? 8'd0 : row_reg;
        dp       = plane_reg - 7'(KM);
        dr       = 7'(row_c - 8'(KM));
        dc       = 7'(col_c - 8'(KM));
        fire = (32'(chan_c) == CHANNELS_IN - 1) && 32'(plane_reg) >= KM &&
               32'(row_c) >= KM && 32'(col_c) >= KM &&
               stride_aligned(dp, st_e) && stride_aligned(dr, st_e) &&
               stride_aligned(dc, st_e);
    end

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign last_tap  = 32'(wi_reg) == CHANNELS_IN - 1 && 32'(kd_reg) == KM &&
                       32'(kh_reg) == KM && 32'(kw_reg) == KM;

    // Ring slot of plane kd in the current window, counted from the slot of its last plane.
    always_comb begin
        kslot_sum = 4'(wslot_reg) + 4'd1 + 4'(kd_reg);
        kslot     = (32'(kslot_sum) >= KERNEL_SIZE) ? 3'(32'(kslot_sum) - KERNEL_SIZE) :
                    kslot_sum[2:0];
    end

    always_comb begin
        cmd.store_weight = accept && item.command == 1'(CMD_WEIGHT) &&
                           32'(item.weight_index) < WCOUNT;
        cmd.store_sample = accept && item.command == 1'(CMD_VOXEL);
        cmd.clear_acc    = (state_reg == S_IDLE) || (state_reg == S_OUT);
        cmd.mac_en       = (state_reg == S_MAC);
        cmd.latch_result = (state_reg == S_RES);
        wr_slot = slot_reg;
        wr_row  = row_c;
        wr_col  = col_c;
        wr_chan = chan_c;
        rd_slot = kslot;
        rd_row  = wrow_reg + 8'(kh_reg);
        rd_col  = wcol_reg + 8'(kw_reg);
        rd_chan = wi_reg;
        rd_widx = widx_reg;
        res_ochan = oc_reg;
        res_plane = opl_reg;
        res_row   = orow_reg;
        res_col   = ocol_reg;
        res_last  = 32'(oc_reg) == CHANNELS_OUT - 1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            depth_reg     <= 7'd34;
            height_reg    <= 7'd34;
            width_reg     <= 7'd34;
            stride_reg    <= 3'd1;
            chan_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            plane_reg     <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
            wi_reg <= '0; kd_reg <= '0; kh_reg <= '0; kw_reg <= '0;
            oc_reg <= '0; widx_reg <= '0; drain_reg <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    2'(CFG_DEPTH):  depth_reg  <= cfg_data;
                    2'(CFG_HEIGHT): height_reg <= cfg_data;
                    2'(CFG_WIDTH):  width_reg  <= cfg_data;
                    2'(CFG_STRIDE): stride_reg <= cfg_data[2:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept && item.command == 1'(CMD_VOXEL)) begin
                        if (fire) begin
                            state_reg <= S_MAC;
                            opl_reg   <= 6'(div_stride(dp, st_e));
                            orow_reg  <= 6'(div_stride(dr, st_e));
                            ocol_reg  <= 6'(div_stride(dc, st_e));
                            wrow_reg  <= row_c - 8'(KM);
                            wcol_reg  <= col_c - 8'(KM);
                            wslot_reg <= slot_reg;
                            wi_reg <= '0; kd_reg <= '0; kh_reg <= '0; kw_reg <= '0;
                            oc_reg <= '0; widx_reg <= '0;
                        end
                        if (32'(chan_c) == CHANNELS_IN - 1) begin
                            chan_reg <= '0;
                            if (col_c + 8'd1 >= width_e) begin
                                col_reg <= '0;
                                if (row_c + 8'd1 >= height_e) begin
                                    row_reg <= '0;
                                    if (plane_reg + 7'd1 >= depth_e) begin
                                        plane_reg <= '0;
                                    end else begin
                                        plane_reg <= plane_reg + 7'd1;
                                    end
                                    slot_reg <= (plane_reg + 7'd1 >= depth_e ||
                                                 32'(slot_reg) == KERNEL_SIZE - 1) ?
                                                3'd0 : slot_reg + 3'd1;
                                end else begin
                                    row_reg <= row_c + 8'd1;
                                end
                            end else begin
                                col_reg <= col_c + 8'd1;
                                row_reg <= row_c;
                            end
                        end else begin
                            chan_reg <= chan_c + 4'd1;
                            col_reg  <= col_c;
                            row_reg  <= row_c;
                        end
                    end
                end
                S_MAC: begin
                    widx_reg <= widx_reg + 16'd1;
                    if (32'(kw_reg) == KM) begin
                        kw_reg <= '0;
                        if (32'(kh_reg) == KM) begin
                            kh_reg <= '0;
                            if (32'(kd_reg) == KM) begin
                                kd_reg <= '0;
                                wi_reg <= last_tap ? 4'd0 : wi_reg + 4'd1;
                            end else begin
                                kd_reg <= kd_reg + 3'd1;
                            end
                        end else begin
                            kh_reg <= kh_reg + 3'd1;
                        end
                    end else begin
                        kw_reg <= kw_reg + 3'd1;
                    end
                    if (last_tap) begin
                        state_reg <= S_DRAIN;
                        drain_reg <= '0;
                    end
                end
                S_DRAIN: begin
                    // Memory read, product and accumulate stages empty out.
                    drain_reg <= drain_reg + 3'd1;
                    if (drain_reg == 3'd2) begin
                        state_reg <= S_RES;
                    end
                end
                S_RES: begin
                    state_reg     <= S_OUT;
                    out_valid_reg <= 1'b1;
                end
                S_OUT: begin
                    if (out_ready) begin
                        if (32'(oc_reg) == CHANNELS_OUT - 1) begin
                            state_reg <= S_IDLE;
                        end else begin
                            oc_reg    <= oc_reg + 6'd1;
                            state_reg <= S_MAC;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* design/c3wr_checker.sv */
`default_nettype none
module c3wr_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire c3wr_pkg::c3wr_out_t m_data
);
    import c3wr_pkg::*;

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while result pending");

    a_beat_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid)
        else $error("result valid right after an input beat");

    a_result_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid)
        else $error("results issued back to back");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule

bind conv3d_window_relu_unit c3wr_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
`default_nettype wire
